// ----- sv/lrk4_pkg.sv -----
// shared types, constants and the micro-program of the lorenz rk4 stepper
package lrk4_pkg;

   localparam int FRAC_BITS = 20;
   localparam int WORD_BITS = 32;
   localparam int PROD_BITS = 2 * WORD_BITS;
   localparam int Q_BITS    = PROD_BITS - FRAC_BITS;

   typedef logic signed [WORD_BITS-1:0] word_type;

   localparam word_type WORD_MAX = {1'b0, {(WORD_BITS-1){1'b1}}};
   localparam word_type WORD_MIN = {1'b1, {(WORD_BITS-1){1'b0}}};

   // ceil(2^33 / 3): floor(n/3) = (n * RECIP3) >> 33 for any 32-bit n
   localparam logic [WORD_BITS-1:0] RECIP3     = 32'hAAAA_AAAB;
   localparam int                   DIV3_SHIFT = 33;
   localparam int                   DIV6_SHIFT = 34;
   localparam logic [PROD_BITS-1:0] ROUND_BIAS = PROD_BITS'(1) << (FRAC_BITS - 1);

   // register reset values, Q12.20
   localparam logic [26:0] SIGMA_RST = 27'(10 << FRAC_BITS);
   localparam logic [27:0] RHO_RST   = 28'(28 << FRAC_BITS);
   localparam logic [24:0] BETA_RST  = 25'(((8 << FRAC_BITS) + 1) / 3);
   localparam logic [20:0] DT_RST    = 21'(1 << (FRAC_BITS - 5));
   localparam word_type    X_RST     = word_type'(15 << FRAC_BITS);
   localparam word_type    Y_RST     = word_type'(15 << FRAC_BITS);
   localparam word_type    Z_RST     = word_type'(36 << FRAC_BITS);

   // configuration register indexes
   localparam logic [1:0] CSR_SIGMA = 2'd0;
   localparam logic [1:0] CSR_RHO   = 2'd1;
   localparam logic [1:0] CSR_BETA  = 2'd2;
   localparam logic [1:0] CSR_DT    = 2'd3;

   // request commands
   localparam logic CMD_LOAD = 1'b0;
   localparam logic CMD_STEP = 1'b1;

   typedef enum logic [2:0] {
      OP_ADD,
      OP_SUB,
      OP_MUL,
      OP_DIV2,
      OP_DIV3,
      OP_DIV6
   } op_type;

   // operand / destination locations: below 16 the scratch memory, 16 and above registers
   typedef logic [4:0] loc_type;

   localparam loc_type L_P0    = 5'd0;
   localparam loc_type L_P1    = 5'd1;
   localparam loc_type L_P2    = 5'd2;
   localparam loc_type L_K0    = 5'd3;
   localparam loc_type L_K1    = 5'd4;
   localparam loc_type L_K2    = 5'd5;
   localparam loc_type L_T0    = 5'd6;
   localparam loc_type L_T1    = 5'd7;
   localparam loc_type L_T2    = 5'd8;
   localparam loc_type L_A0    = 5'd9;
   localparam loc_type L_A1    = 5'd10;
   localparam loc_type L_A2    = 5'd11;
   localparam loc_type L_S0    = 5'd16;
   localparam loc_type L_S1    = 5'd17;
   localparam loc_type L_S2    = 5'd18;
   localparam loc_type L_SIGMA = 5'd19;
   localparam loc_type L_RHO   = 5'd20;
   localparam loc_type L_BETA  = 5'd21;
   localparam loc_type L_DT    = 5'd22;
   localparam loc_type L_ZERO  = 5'd23;

   localparam int SCRATCH_DEPTH = 12;
   localparam int SCRATCH_AW    = 4;

   typedef struct packed {
      op_type  op;
      loc_type dst;
      loc_type src_a;
      loc_type src_b;
   } uop_type;

   localparam int          PC_BITS   = 7;
   localparam logic [6:0]  PROG_LAST = 7'd86;
   localparam logic [6:0]  U1_BASE   = 7'd12;
   localparam logic [6:0]  D2_BASE   = 7'd24;
   localparam logic [6:0]  U2_BASE   = 7'd36;
   localparam logic [6:0]  D3_BASE   = 7'd48;
   localparam logic [6:0]  U3_BASE   = 7'd60;
   localparam logic [6:0]  D4_BASE   = 7'd69;
   localparam logic [6:0]  U4_BASE   = 7'd81;

   function automatic uop_type mk(op_type op, loc_type d, loc_type a, loc_type b);
      uop_type u;
      u.op    = op;
      u.dst   = d;
      u.src_a = a;
      u.src_b = b;
      return u;
   endfunction

   // one evaluation of the field at point (x, y, z), scaled by dt, into k
   function automatic uop_type deriv_uop(logic [3:0] i, loc_type x, loc_type y, loc_type z);
      uop_type u;
      unique case (i)
         4'd0:    u = mk(OP_SUB, L_T0, y, x);
         4'd1:    u = mk(OP_MUL, L_T0, L_SIGMA, L_T0);
         4'd2:    u = mk(OP_MUL, L_K0, L_T0, L_DT);
         4'd3:    u = mk(OP_MUL, L_T1, L_RHO, x);
         4'd4:    u = mk(OP_SUB, L_T1, L_T1, y);
         4'd5:    u = mk(OP_MUL, L_T2, x, z);
         4'd6:    u = mk(OP_SUB, L_T1, L_T1, L_T2);
         4'd7:    u = mk(OP_MUL, L_K1, L_T1, L_DT);
         4'd8:    u = mk(OP_MUL, L_T2, x, y);
         4'd9:    u = mk(OP_MUL, L_T0, L_BETA, z);
         4'd10:   u = mk(OP_SUB, L_T2, L_T2, L_T0);
         default: u = mk(OP_MUL, L_K2, L_T2, L_DT);
      endcase
      return u;
   endfunction

   // after k1: p = s + k/2, acc = s + k/6
   function automatic uop_type upd1_uop(logic [3:0] i);
      uop_type u;
      unique case (i)
         4'd0:    u = mk(OP_DIV2, L_T0, L_K0, L_ZERO);
         4'd1:    u = mk(OP_ADD,  L_P0, L_S0, L_T0);
         4'd2:    u = mk(OP_DIV6, L_A0, L_K0, L_ZERO);
         4'd3:    u = mk(OP_ADD,  L_A0, L_S0, L_A0);
         4'd4:    u = mk(OP_DIV2, L_T1, L_K1, L_ZERO);
         4'd5:    u = mk(OP_ADD,  L_P1, L_S1, L_T1);
         4'd6:    u = mk(OP_DIV6, L_A1, L_K1, L_ZERO);
         4'd7:    u = mk(OP_ADD,  L_A1, L_S1, L_A1);
         4'd8:    u = mk(OP_DIV2, L_T2, L_K2, L_ZERO);
         4'd9:    u = mk(OP_ADD,  L_P2, L_S2, L_T2);
         4'd10:   u = mk(OP_DIV6, L_A2, L_K2, L_ZERO);
         default: u = mk(OP_ADD,  L_A2, L_S2, L_A2);
      endcase
      return u;
   endfunction

   // after k2: acc += k/3, p = s + k/2
   function automatic uop_type upd2_uop(logic [3:0] i);
      uop_type u;
      unique case (i)
         4'd0:    u = mk(OP_DIV3, L_T0, L_K0, L_ZERO);
         4'd1:    u = mk(OP_ADD,  L_A0, L_A0, L_T0);
         4'd2:    u = mk(OP_DIV2, L_T0, L_K0, L_ZERO);
         4'd3:    u = mk(OP_ADD,  L_P0, L_S0, L_T0);
         4'd4:    u = mk(OP_DIV3, L_T1, L_K1, L_ZERO);
         4'd5:    u = mk(OP_ADD,  L_A1, L_A1, L_T1);
         4'd6:    u = mk(OP_DIV2, L_T1, L_K1, L_ZERO);
         4'd7:    u = mk(OP_ADD,  L_P1, L_S1, L_T1);
         4'd8:    u = mk(OP_DIV3, L_T2, L_K2, L_ZERO);
         4'd9:    u = mk(OP_ADD,  L_A2, L_A2, L_T2);
         4'd10:   u = mk(OP_DIV2, L_T2, L_K2, L_ZERO);
         default: u = mk(OP_ADD,  L_P2, L_S2, L_T2);
      endcase
      return u;
   endfunction

   // after k3: acc += k/3, p = s + k
   function automatic uop_type upd3_uop(logic [3:0] i);
      uop_type u;
      unique case (i)
         4'd0:    u = mk(OP_DIV3, L_T0, L_K0, L_ZERO);
         4'd1:    u = mk(OP_ADD,  L_A0, L_A0, L_T0);
         4'd2:    u = mk(OP_ADD,  L_P0, L_S0, L_K0);
         4'd3:    u = mk(OP_DIV3, L_T1, L_K1, L_ZERO);
         4'd4:    u = mk(OP_ADD,  L_A1, L_A1, L_T1);
         4'd5:    u = mk(OP_ADD,  L_P1, L_S1, L_K1);
         4'd6:    u = mk(OP_DIV3, L_T2, L_K2, L_ZERO);
         4'd7:    u = mk(OP_ADD,  L_A2, L_A2, L_T2);
         default: u = mk(OP_ADD,  L_P2, L_S2, L_K2);
      endcase
      return u;
   endfunction

   // after k4: s = acc + k/6
   function automatic uop_type upd4_uop(logic [3:0] i);
      uop_type u;
      unique case (i)
         4'd0:    u = mk(OP_DIV6, L_T0, L_K0, L_ZERO);
         4'd1:    u = mk(OP_ADD,  L_S0, L_A0, L_T0);
         4'd2:    u = mk(OP_DIV6, L_T1, L_K1, L_ZERO);
         4'd3:    u = mk(OP_ADD,  L_S1, L_A1, L_T1);
         4'd4:    u = mk(OP_DIV6, L_T2, L_K2, L_ZERO);
         default: u = mk(OP_ADD,  L_S2, L_A2, L_T2);
      endcase
      return u;
   endfunction

   function automatic uop_type prog_rom(logic [PC_BITS-1:0] pc);
      uop_type u;
      priority if (pc < U1_BASE) begin
         u = deriv_uop(pc[3:0], L_S0, L_S1, L_S2);
      end else if (pc < D2_BASE) begin
         u = upd1_uop(4'(pc - U1_BASE));
      end else if (pc < U2_BASE) begin
         u = deriv_uop(4'(pc - D2_BASE), L_P0, L_P1, L_P2);
      end else if (pc < D3_BASE) begin
         u = upd2_uop(4'(pc - U2_BASE));
      end else if (pc < U3_BASE) begin
         u = deriv_uop(4'(pc - D3_BASE), L_P0, L_P1, L_P2);
      end else if (pc < D4_BASE) begin
         u = upd3_uop(4'(pc - U3_BASE));
      end else if (pc < U4_BASE) begin
         u = deriv_uop(4'(pc - D4_BASE), L_P0, L_P1, L_P2);
      end else begin
         u = upd4_uop(4'(pc - U4_BASE));
      end
      return u;
   endfunction

endpackage

// ----- sv/lorenz_rk4_step.sv -----
// lorenz attractor integrator, one classical runge-kutta step per step request
//
// Keeps the Lorenz state (x, y, z) in signed Q12.20 and answers every request with
// the state as it stands afterwards. A request with tuser = 0 loads the state from
// tdata; tuser = 1 advances it by one fourth-order Runge-Kutta step with the gains
// sigma, rho, beta and step size dt from the register port. All arithmetic saturates
// to 32 bits and rsp_tuser flags any saturation during the request. A step runs as a
// micro-program of 87 operations (four field evaluations and the weighted updates) on
// one shared unit: a 32x32 multiplier, a saturating adder and a rounding/saturation
// stage. Each operation passes in turn through the scratch read, operand prep,
// execute and write back states; after the last one, as after a load, the block hands
// the state to the response register once that is free. Division of k by 3 and 6
// goes through the same multiplier as a reciprocal product. The block
// takes no request while a step is running; a finished response waits in its own
// register, and the next request is accepted while it waits.
module lorenz_rk4_step (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [95:0] req_tdata,   // load_x [31:0], load_y [63:32], load_z [95:64]
   input  logic        req_tuser,   // command: 0 load, 1 step
   // response channel
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [95:0] rsp_tdata,   // pos_x [31:0], pos_y [63:32], pos_z [95:64]
   output logic        rsp_tuser,   // overflow
   // register write port
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [27:0] csr_wdata
);
   import lrk4_pkg::*;

   // sequencer: idle, one state per phase of a micro-operation, and done
   typedef enum logic [5:0] {
      ST_IDLE  = 6'b000001,
      ST_READ  = 6'b000010,
      ST_PREP  = 6'b000100,
      ST_EXEC  = 6'b001000,
      ST_WRITE = 6'b010000,
      ST_DONE  = 6'b100000
   } state_type;

   state_type state_ff, state_in;
   logic [PC_BITS-1:0] pc_ff, pc_in;

   // configuration
   logic [26:0] sigma_ff, sigma_in;
   logic [27:0] rho_ff,   rho_in;
   logic [24:0] beta_ff,  beta_in;
   logic [20:0] dt_ff,    dt_in;

   // integrator state
   word_type sx_ff, sx_in, sy_ff, sy_in, sz_ff, sz_in;

   // shared unit pipeline registers
   word_type                rd_a_ff, rd_b_ff;
   logic [WORD_BITS-1:0]    x_ff, x_in, y_ff, y_in;
   logic                    neg_ff, neg_in;
   logic [PROD_BITS-1:0]    prod_ff, prod_in;
   word_type                res_ff, res_in;
   logic                    sat_ff, sat_in;

   // response register
   logic        rsp_valid_ff, rsp_valid_in;
   logic [95:0] rsp_data_ff,  rsp_data_in;
   logic        rsp_sat_ff,   rsp_sat_in;

   // scratch memory for p, k, temporaries and accumulators
   word_type                 scratch_mem [SCRATCH_DEPTH];
   logic                     mem_we;
   logic [SCRATCH_AW-1:0]    mem_addr;
   word_type                 mem_wdata;

   uop_type  cur;
   word_type opa, opb;
   logic [WORD_BITS-1:0] ma, mb;
   logic [PROD_BITS-1:0] product, rnd;
   logic signed [WORD_BITS:0] sum;
   logic [Q_BITS-1:0] q;
   word_type wval;
   logic     wsat;
   logic     req_fire;

   function automatic word_type sel_operand(
      loc_type     code,
      word_type    mem,
      word_type    sx,
      word_type    sy,
      word_type    sz,
      logic [26:0] sig,
      logic [27:0] rho,
      logic [24:0] beta,
      logic [20:0] dt
   );
      word_type v;
      unique case (code)
         L_S0:    v = sx;
         L_S1:    v = sy;
         L_S2:    v = sz;
         L_SIGMA: v = word_type'({5'd0, sig});
         L_RHO:   v = word_type'({4'd0, rho});
         L_BETA:  v = word_type'({7'd0, beta});
         L_DT:    v = word_type'({11'd0, dt});
         L_ZERO:  v = '0;
         default: v = mem;
      endcase
      return v;
   endfunction

   assign cur        = prog_rom(pc_ff);
   assign req_tready = (state_ff == ST_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_sat_ff;

   // operands come from the registered scratch read or from the register side
   assign opa = sel_operand(cur.src_a, rd_a_ff, sx_ff, sy_ff, sz_ff,
                            sigma_ff, rho_ff, beta_ff, dt_ff);
   assign opb = sel_operand(cur.src_b, rd_b_ff, sx_ff, sy_ff, sz_ff,
                            sigma_ff, rho_ff, beta_ff, dt_ff);
   assign ma  = opa[WORD_BITS-1] ? (~opa + 1'b1) : opa;
   assign mb  = opb[WORD_BITS-1] ? (~opb + 1'b1) : opb;

   // the one multiplier and the one adder
   assign product = PROD_BITS'(x_ff) * PROD_BITS'(y_ff);
   assign sum     = {x_ff[WORD_BITS-1], x_ff} + {y_ff[WORD_BITS-1], y_ff};

   // rounding and scaling of the product, depending on the operation
   assign rnd = prod_ff + ROUND_BIAS;
   always_comb begin
      unique case (cur.op)
         OP_DIV2: q = Q_BITS'(prod_ff >> 1);
         OP_DIV3: q = Q_BITS'(prod_ff >> DIV3_SHIFT);
         OP_DIV6: q = Q_BITS'(prod_ff >> DIV6_SHIFT);
         default: q = rnd[PROD_BITS-1:FRAC_BITS];
      endcase
   end

   // magnitude back to a signed word, saturating
   always_comb begin
      wsat = 1'b0;
      if (cur.op == OP_ADD || cur.op == OP_SUB) begin
         wval = res_ff;
      end else if (neg_ff) begin
         if (q > Q_BITS'({1'b1, {(WORD_BITS-1){1'b0}}})) begin
            wval = WORD_MIN;
            wsat = 1'b1;
         end else begin
            wval = word_type'(~q[WORD_BITS-1:0] + 1'b1);
         end
      end else begin
         if (q > Q_BITS'(WORD_MAX)) begin
            wval = WORD_MAX;
            wsat = 1'b1;
         end else begin
            wval = word_type'(q[WORD_BITS-1:0]);
         end
      end
   end

   always_comb begin
      state_in     = state_ff;
      pc_in        = pc_ff;
      sigma_in     = sigma_ff;
      rho_in       = rho_ff;
      beta_in      = beta_ff;
      dt_in        = dt_ff;
      sx_in        = sx_ff;
      sy_in        = sy_ff;
      sz_in        = sz_ff;
      x_in         = x_ff;
      y_in         = y_ff;
      neg_in       = neg_ff;
      prod_in      = prod_ff;
      res_in       = res_ff;
      sat_in       = sat_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      rsp_sat_in   = rsp_sat_ff;
      mem_we       = 1'b0;
      mem_addr     = cur.dst[SCRATCH_AW-1:0];
      mem_wdata    = wval;

      // register writes are taken at any time
      if (csr_we) begin
         unique case (csr_index)
            CSR_SIGMA: sigma_in = csr_wdata[26:0];
            CSR_RHO:   rho_in   = csr_wdata;
            CSR_BETA:  beta_in  = csr_wdata[24:0];
            CSR_DT:    dt_in    = csr_wdata[20:0];
            default:   ;
         endcase
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               sat_in = 1'b0;
               if (req_tuser == CMD_LOAD) begin
                  sx_in    = word_type'(req_tdata[31:0]);
                  sy_in    = word_type'(req_tdata[63:32]);
                  sz_in    = word_type'(req_tdata[95:64]);
                  state_in = ST_DONE;
               end else begin
                  pc_in    = '0;
                  state_in = ST_READ;
               end
            end
         end
         ST_READ: begin
            state_in = ST_PREP;
         end
         ST_PREP: begin
            // magnitudes and sign for the multiplier, negation for a subtract
            neg_in = opa[WORD_BITS-1];
            unique case (cur.op)
               OP_MUL: begin
                  x_in   = ma;
                  y_in   = mb;
                  neg_in = opa[WORD_BITS-1] ^ opb[WORD_BITS-1];
               end
               OP_DIV2: begin
                  x_in = ma + 1'b1;
                  y_in = RECIP3;
               end
               OP_DIV3: begin
                  x_in = ma + 1'b1;
                  y_in = RECIP3;
               end
               OP_DIV6: begin
                  x_in = ma + WORD_BITS'(3);
                  y_in = RECIP3;
               end
               OP_ADD: begin
                  x_in = opa;
                  y_in = opb;
               end
               OP_SUB: begin
                  x_in = opa;
                  // negating the most negative word saturates and counts
                  if (opb == WORD_MIN) begin
                     y_in   = WORD_MAX;
                     sat_in = 1'b1;
                  end else begin
                     y_in = ~opb + 1'b1;
                  end
               end
               default: ;
            endcase
            state_in = ST_EXEC;
         end
         ST_EXEC: begin
            prod_in = (cur.op == OP_DIV2) ? PROD_BITS'(x_ff) : product;
            if (sum > (WORD_BITS+1)'(WORD_MAX)) begin
               res_in = WORD_MAX;
            end else if (sum < (WORD_BITS+1)'(WORD_MIN)) begin
               res_in = WORD_MIN;
            end else begin
               res_in = sum[WORD_BITS-1:0];
            end
            if ((cur.op == OP_ADD || cur.op == OP_SUB) &&
                (sum[WORD_BITS] != sum[WORD_BITS-1])) begin
               sat_in = 1'b1;
            end
            state_in = ST_WRITE;
         end
         ST_WRITE: begin
            if (wsat) begin
               sat_in = 1'b1;
            end
            if (!cur.dst[4]) begin
               mem_we = 1'b1;
            end else if (cur.dst == L_S0) begin
               sx_in = wval;
            end else if (cur.dst == L_S1) begin
               sy_in = wval;
            end else if (cur.dst == L_S2) begin
               sz_in = wval;
            end
            if (pc_ff == PROG_LAST) begin
               state_in = ST_DONE;
            end else begin
               pc_in    = pc_ff + 1'b1;
               state_in = ST_READ;
            end
         end
         ST_DONE: begin
            // hand the state over once the response register is free
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {sz_ff, sy_ff, sx_ff};
               rsp_sat_in   = sat_ff;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // control and architectural state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         pc_ff        <= '0;
         sigma_ff     <= SIGMA_RST;
         rho_ff       <= RHO_RST;
         beta_ff      <= BETA_RST;
         dt_ff        <= DT_RST;
         sx_ff        <= X_RST;
         sy_ff        <= Y_RST;
         sz_ff        <= Z_RST;
         sat_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pc_ff        <= pc_in;
         sigma_ff     <= sigma_in;
         rho_ff       <= rho_in;
         beta_ff      <= beta_in;
         dt_ff        <= dt_in;
         sx_ff        <= sx_in;
         sy_ff        <= sy_in;
         sz_ff        <= sz_in;
         sat_ff       <= sat_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // datapath payload, no reset
   always_ff @(posedge clock) begin
      x_ff        <= x_in;
      y_ff        <= y_in;
      neg_ff      <= neg_in;
      prod_ff     <= prod_in;
      res_ff      <= res_in;
      rsp_data_ff <= rsp_data_in;
      rsp_sat_ff  <= rsp_sat_in;
   end

   // scratch memory: one write port, two registered read ports
   always_ff @(posedge clock) begin
      if (mem_we) begin
         scratch_mem[mem_addr] <= mem_wdata;
      end
      if (state_ff == ST_READ) begin
         rd_a_ff <= scratch_mem[cur.src_a[SCRATCH_AW-1:0]];
         rd_b_ff <= scratch_mem[cur.src_b[SCRATCH_AW-1:0]];
      end
   end

endmodule
